// ===== rtl/fci_pkg.sv =====
// shared constants, types and coefficient tables of the force coefficient interpolator
package fci_pkg;

  localparam int TABLE_POINTS = 19;
  localparam int LAST_IDX     = TABLE_POINTS - 1;
  localparam int FRAC_BITS    = 13;

  localparam int ANGLE_W  = 16;
  localparam int AXIAL_W  = 14;
  localparam int NORMAL_W = 13;

  // segments per radian, 10-degree segments, with KSEG_FRAC fraction bits
  localparam int KSEG_W    = 27;
  localparam int KSEG_FRAC = 24;
  localparam logic [KSEG_W-1:0] KSEG = 27'd96126367;

  localparam int WEIGHT_BITS = 16;
  localparam int PROD_W      = ANGLE_W + KSEG_W;
  localparam int SEG_LSB     = FRAC_BITS + KSEG_FRAC;
  localparam int T_LSB       = SEG_LSB - WEIGHT_BITS;
  localparam int SEG_W       = PROD_W - SEG_LSB;
  localparam int IDX_W       = 5;

  // table points are hundredths
  localparam int COEF_W = 9;
  localparam int LERP_W = COEF_W + WEIGHT_BITS;
  localparam int MAG_W  = LERP_W - 1;

  // hundredths with WEIGHT_BITS fraction bits to Q.FRAC_BITS:
  // q = floor((mag + ROUND_OFS) / (25 << DEN_SHIFT))
  localparam int ROUND_OFS   = 50 << (WEIGHT_BITS - FRAC_BITS);
  localparam int DEN_SHIFT   = WEIGHT_BITS - FRAC_BITS + 2;
  localparam int SCALED_W    = MAG_W + 1 - DEN_SHIFT;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP = 20'd671089;  // ceil(2^24 / 25)
  localparam int SPROD_W     = SCALED_W + RECIP_W;
  localparam int QUOT_W      = SPROD_W - RECIP_SHIFT;
  localparam int RES_W       = QUOT_W + 1;

  localparam int AXIAL_MAX  = (2 ** AXIAL_W) - 1;
  localparam int NORMAL_MAX = (2 ** (NORMAL_W - 1)) - 1;
  localparam int NORMAL_MIN = -(2 ** (NORMAL_W - 1));

  // angle reg, segment product, interpolation, scaling, output
  localparam int NUM_STAGES = 5;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [WEIGHT_BITS-1:0]   weight_t;
  typedef logic signed [RES_W-1:0]  res_t;

  typedef struct packed {
    logic angle_load;
    logic prod_load;
  } seg_en_t;

  typedef struct packed {
    logic lerp_load;
    logic scale_load;
  } lerp_en_t;

  function automatic coef_t axial_point(input idx_t idx);
    coef_t c;
    unique case (idx)
      5'd0:    c = 9'sd170;
      5'd1:    c = 9'sd164;
      5'd2:    c = 9'sd147;
      5'd3:    c = 9'sd124;
      5'd4:    c = 9'sd100;
      5'd5:    c = 9'sd86;
      5'd6:    c = 9'sd80;
      5'd7:    c = 9'sd80;
      5'd8:    c = 9'sd92;
      5'd9:    c = 9'sd104;
      5'd10:   c = 9'sd116;
      5'd11:   c = 9'sd120;
      5'd12:   c = 9'sd120;
      5'd13:   c = 9'sd114;
      5'd14:   c = 9'sd103;
      5'd15:   c = 9'sd94;
      5'd16:   c = 9'sd83;
      5'd17:   c = 9'sd81;
      5'd18:   c = 9'sd80;
      default: c = 9'sd0;
    endcase
    return c;
  endfunction

  function automatic coef_t normal_point(input idx_t idx);
    coef_t c;
    unique case (idx)
      5'd0:    c = 9'sd0;
      5'd1:    c = 9'sd22;
      5'd2:    c = 9'sd41;
      5'd3:    c = 9'sd46;
      5'd4:    c = 9'sd39;
      5'd5:    c = 9'sd20;
      5'd6:    c = 9'sd2;
      5'd7:    c = -9'sd14;
      5'd8:    c = -9'sd21;
      5'd9:    c = -9'sd21;
      5'd10:   c = -9'sd18;
      5'd11:   c = -9'sd2;
      5'd12:   c = 9'sd7;
      5'd13:   c = 9'sd15;
      5'd14:   c = 9'sd19;
      5'd15:   c = 9'sd18;
      5'd16:   c = 9'sd14;
      5'd17:   c = 9'sd6;
      5'd18:   c = 9'sd0;
      default: c = 9'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/fci_angle_if.sv =====
// request channel carrying one attack angle
interface fci_angle_if import fci_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] attack_angle;

  modport source (output valid, output attack_angle, input ready);
  modport sink   (input valid, input attack_angle, output ready);
endinterface

// ===== rtl/fci_coeff_if.sv =====
// result channel carrying the interpolated force coefficients
interface fci_coeff_if import fci_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [AXIAL_W-1:0]         axial_coeff;
  logic signed [NORMAL_W-1:0] normal_coeff;
  logic                       angle_clamped;

  modport source (output valid, output axial_coeff, output normal_coeff,
                  output angle_clamped, input ready);
  modport sink   (input valid, input axial_coeff, input normal_coeff,
                  input angle_clamped, output ready);
endinterface

// ===== rtl/force_coefficient_interpolator_unit.sv =====
// top level: pipelined axial/normal force coefficient interpolation over attack angle
//
// Takes one attack angle (radians, signed Q2.13) per cycle and returns the axial
// (unsigned Q1.13) and normal (signed, 13 fraction bits) force coefficients
// interpolated every 10 degrees of |angle| from 0 to 180 degrees. Angles beyond 180
// degrees give the 180-degree point and set angle_clamped. Throughput is one request
// per clock while the output is not stalled. There are five register stages: input
// register, angle-to-segment multiply, table lookup and interpolation multiply,
// reciprocal scaling multiply, then the saturating output register. A result is
// presented once its request has passed all five registers and can leave at the next
// edge. Each stage holds while it is full and its successor cannot load, so up to 5
// requests are in flight. There is no configuration and no state between requests.
module force_coefficient_interpolator_unit import fci_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  fci_angle_if.sink          angle_i,
  fci_coeff_if.source        coeff_o
);

  localparam int OUT_STAGE = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] vld_d, vld_q;
  logic [NUM_STAGES-1:0] load;

  seg_en_t  seg_en;
  lerp_en_t lerp_en;

  idx_t    seg, seg_nxt;
  weight_t t_w;
  logic    clamp;
  logic    clamp2_q, clamp3_q;

  res_t ax_res, nr_res;
  logic [AXIAL_W-1:0]         ax_sat;
  logic signed [NORMAL_W-1:0] nr_sat;

  logic [AXIAL_W-1:0]         axial_q;
  logic signed [NORMAL_W-1:0] normal_q;
  logic                       clamp_q;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    load[OUT_STAGE] = !vld_q[OUT_STAGE] || coeff_o.ready;
    for (int k = OUT_STAGE - 1; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
  end

  always_comb begin
    vld_d[0] = load[0] ? angle_i.valid : vld_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_d[k] = load[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign angle_i.ready = load[0];

  assign seg_en  = '{angle_load: load[0], prod_load: load[1]};
  assign lerp_en = '{lerp_load: load[2], scale_load: load[3]};

  fci_segment u_segment (
    .clk_i   (clk_i),
    .en_i    (seg_en),
    .angle_i (angle_i.attack_angle),
    .seg_o   (seg),
    .t_o     (t_w),
    .clamp_o (clamp)
  );

  // upper neighbor repeats the last point
  assign seg_nxt = (seg == IDX_W'(LAST_IDX)) ? seg : seg + IDX_W'(1);

  fci_lerp u_lerp_axial (
    .clk_i (clk_i),
    .en_i  (lerp_en),
    .c0_i  (axial_point(seg)),
    .c1_i  (axial_point(seg_nxt)),
    .t_i   (t_w),
    .res_o (ax_res)
  );

  fci_lerp u_lerp_normal (
    .clk_i (clk_i),
    .en_i  (lerp_en),
    .c0_i  (normal_point(seg)),
    .c1_i  (normal_point(seg_nxt)),
    .t_i   (t_w),
    .res_o (nr_res)
  );

  always_comb begin
    priority if (ax_res < res_t'(0)) begin
      ax_sat = '0;
    end else if (ax_res > res_t'(AXIAL_MAX)) begin
      ax_sat = AXIAL_W'(AXIAL_MAX);
    end else begin
      ax_sat = ax_res[AXIAL_W-1:0];
    end
  end

  always_comb begin
    priority if (nr_res < res_t'(NORMAL_MIN)) begin
      nr_sat = NORMAL_W'(NORMAL_MIN);
    end else if (nr_res > res_t'(NORMAL_MAX)) begin
      nr_sat = NORMAL_W'(NORMAL_MAX);
    end else begin
      nr_sat = nr_res[NORMAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      clamp2_q <= clamp;
    end
    if (load[3]) begin
      clamp3_q <= clamp2_q;
    end
    if (load[OUT_STAGE]) begin
      axial_q  <= ax_sat;
      normal_q <= nr_sat;
      clamp_q  <= clamp3_q;
    end
  end

  assign coeff_o.valid         = vld_q[OUT_STAGE];
  assign coeff_o.axial_coeff   = axial_q;
  assign coeff_o.normal_coeff  = normal_q;
  assign coeff_o.angle_clamped = clamp_q;

`ifndef NO_ASSERTIONS
  // 180-degree point: axial 0.80, normal 0.00
  localparam logic [AXIAL_W-1:0] AXIAL_END_Q = 14'd6554;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (angle_i.valid && angle_i.ready) |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !angle_i.ready |-> (&vld_q && !coeff_o.ready))
    else $error("input stalled while a pipeline stage was free");

  a_clamp_last_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (coeff_o.valid && coeff_o.angle_clamped) |->
      (coeff_o.axial_coeff == AXIAL_END_Q && coeff_o.normal_coeff == '0))
    else $error("clamped angle did not return the last table point");
`endif

endmodule

// ===== rtl/fci_segment.sv =====
// angle register, angle-to-segment multiply and segment/weight decode
module fci_segment import fci_pkg::*; (
  input  logic                      clk_i,
  input  seg_en_t                   en_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output idx_t                      seg_o,
  output weight_t                   t_o,
  output logic                      clamp_o
);

  logic signed [ANGLE_W-1:0] angle_q;
  logic [ANGLE_W-1:0]        mag;
  logic [PROD_W-1:0]         prod_d, prod_q;
  logic [SEG_W-1:0]          seg_raw;
  logic                      frac_nz;

  always_ff @(posedge clk_i) begin
    if (en_i.angle_load) begin
      angle_q <= angle_i;
    end
    if (en_i.prod_load) begin
      prod_q <= prod_d;
    end
  end

  // most negative input wraps to magnitude 2^15, which still fits unsigned
  assign mag = angle_q[ANGLE_W-1] ? (~$unsigned(angle_q) + ANGLE_W'(1))
                                  : $unsigned(angle_q);
  assign prod_d = PROD_W'(mag) * PROD_W'(KSEG);

  assign seg_raw = prod_q[PROD_W-1:SEG_LSB];
  assign frac_nz = |prod_q[SEG_LSB-1:0];

  always_comb begin
    if (seg_raw >= SEG_W'(LAST_IDX)) begin
      // at or past 180 degrees: pin to the last point
      seg_o   = IDX_W'(LAST_IDX);
      t_o     = '0;
      clamp_o = (seg_raw > SEG_W'(LAST_IDX)) || frac_nz;
    end else begin
      seg_o   = seg_raw[IDX_W-1:0];
      t_o     = prod_q[SEG_LSB-1:T_LSB];
      clamp_o = 1'b0;
    end
  end

endmodule

// ===== rtl/fci_lerp.sv =====
// linear interpolation in hundredths and rounded scaling to Q.FRAC_BITS
module fci_lerp import fci_pkg::*; (
  input  logic     clk_i,
  input  lerp_en_t en_i,
  input  coef_t    c0_i,
  input  coef_t    c1_i,
  input  weight_t  t_i,
  output res_t     res_o
);

  logic signed [COEF_W:0]        diff;
  logic signed [WEIGHT_BITS:0]   t_s;
  logic signed [LERP_W+1:0]      base, term, lerp_full;
  logic signed [LERP_W-1:0]      lerp_q;
  logic                          neg;
  logic [LERP_W-1:0]             abs_v;
  logic [MAG_W:0]                round_sum;
  logic [SCALED_W-1:0]           scaled;
  logic [SPROD_W-1:0]            sprod_d, sprod_q;
  logic                          neg_q;
  logic [QUOT_W-1:0]             quot;
  res_t                          quot_s;

  assign diff      = (COEF_W+1)'(c1_i) - (COEF_W+1)'(c0_i);
  assign t_s       = $signed({1'b0, t_i});
  assign base      = (LERP_W+2)'(c0_i) <<< WEIGHT_BITS;
  assign term      = t_s * diff;
  assign lerp_full = base + term;

  // magnitude stays below 2^24, rounding is symmetric about zero
  assign neg       = lerp_q[LERP_W-1];
  assign abs_v     = neg ? (~$unsigned(lerp_q) + LERP_W'(1)) : $unsigned(lerp_q);
  assign round_sum = {1'b0, abs_v[MAG_W-1:0]} + (MAG_W+1)'(ROUND_OFS);
  assign scaled    = round_sum[MAG_W:DEN_SHIFT];
  assign sprod_d   = SPROD_W'(scaled) * SPROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i.lerp_load) begin
      lerp_q <= lerp_full[LERP_W-1:0];
    end
    if (en_i.scale_load) begin
      sprod_q <= sprod_d;
      neg_q   <= neg;
    end
  end

  assign quot   = sprod_q[SPROD_W-1:RECIP_SHIFT];
  assign quot_s = $signed({1'b0, quot});
  assign res_o  = neg_q ? -quot_s : quot_s;

endmodule

// ===== test/force_coefficient_interpolator_unit_test.sv =====
// self-checking testbench for the force coefficient interpolator unit
module force_coefficient_interpolator_unit_test;
  import fci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_COUNT   = 1750;
  localparam int CALM_FIRST   = 300;    // sender stretch with no idling
  localparam int CALM_LAST    = 700;
  localparam int HOLD_START   = 150;    // receiver hold-off, in cycles after reset
  localparam int HOLD_CYCLES  = 80;
  localparam int READY_CALM_A = 1200;   // receiver stretch with no stalls
  localparam int READY_CALM_B = 1700;
  localparam int IDLE_PCT     = 21;
  localparam int DRAIN_CYCLES = 2 * NUM_STAGES + 4;

  typedef struct packed {
    logic [AXIAL_W-1:0]         axial;
    logic signed [NORMAL_W-1:0] normal;
    logic                       clamped;
  } coeff_set_t;

  class coeff_ledger;
    // segment position per radian, 24 fraction bits
    localparam longint unsigned SEGS_PER_RAD = 64'd96126367;
    localparam int              POS_FRAC     = 13 + 24;

    int axial_pts[19] = '{170, 164, 147, 124, 100, 86, 80, 80, 92, 104,
                          116, 120, 120, 114, 103, 94, 83, 81, 80};
    int normal_pts[19] = '{0, 22, 41, 46, 39, 20, 2, -14, -21, -21,
                           -18, -2, 7, 15, 19, 18, 14, 6, 0};
    coeff_set_t pending_coeffs[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // hundredths with 16 weight bits, scaled to Q.13, ties away from zero
    function longint lerp_q13(int c0, int c1, longint unsigned w);
      longint          v;
      longint unsigned m;
      longint unsigned q;
      v = longint'(c0) * 65536 + longint'(w) * longint'(c1 - c0);
      m = (v < 0) ? longint'(-v) : v;
      q = ((m << 13) + 64'd3276800) / 64'd6553600;
      return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function coeff_set_t interpolate(logic [ANGLE_W-1:0] raw);
      longint unsigned mag;
      longint unsigned pos;
      longint unsigned seg;
      longint unsigned frac;
      longint unsigned w;
      longint          ax;
      longint          nr;
      int              i0;
      int              i1;
      coeff_set_t      res;
      mag  = raw[ANGLE_W-1] ? (64'd65536 - raw) : raw;
      pos  = mag * SEGS_PER_RAD;
      seg  = pos >> POS_FRAC;
      frac = pos & ((64'd1 << POS_FRAC) - 1);
      res.clamped = 1'b0;
      if (seg >= 18) begin
        // at or past 180 degrees the last point is used
        res.clamped = (seg > 18) || (frac != 0);
        i0 = 18;
        w  = 0;
      end else begin
        i0 = int'(seg);
        w  = (pos >> (POS_FRAC - 16)) & 64'hFFFF;
      end
      i1 = (i0 < 18) ? i0 + 1 : i0;
      ax = lerp_q13(axial_pts[i0], axial_pts[i1], w);
      nr = lerp_q13(normal_pts[i0], normal_pts[i1], w);
      if (ax < 0) ax = 0;
      if (ax > 16383) ax = 16383;
      if (nr < -4096) nr = -4096;
      if (nr > 4095) nr = 4095;
      res.axial  = ax[AXIAL_W-1:0];
      res.normal = nr[NORMAL_W-1:0];
      return res;
    endfunction

    function void note_angle(logic [ANGLE_W-1:0] raw);
      pending_coeffs.push_back(interpolate(raw));
    endfunction

    function void report(string what, coeff_set_t exp_c, coeff_set_t got_c);
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch (%s): expected axial %0d normal %0d clamped %0d, ",
                  "got axial %0d normal %0d clamped %0d"},
                 what, exp_c.axial, exp_c.normal, exp_c.clamped,
                 got_c.axial, got_c.normal, got_c.clamped);
    endfunction

    function void check_coeffs(coeff_set_t got_c);
      coeff_set_t exp_c;
      if (pending_coeffs.size() == 0) begin
        report("no request outstanding", '0, got_c);
        return;
      end
      exp_c = pending_coeffs.pop_front();
      if (got_c.axial !== exp_c.axial) report("axial_coeff", exp_c, got_c);
      if (got_c.normal !== exp_c.normal) report("normal_coeff", exp_c, got_c);
      if (got_c.clamped !== exp_c.clamped) report("angle_clamped", exp_c, got_c);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  fci_angle_if angle_bus ();
  fci_coeff_if coeff_bus ();

  force_coefficient_interpolator_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .angle_i (angle_bus),
    .coeff_o (coeff_bus)
  );

  coeff_ledger ledger = new();
  bit          sender_calm;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_angle(input logic [ANGLE_W-1:0] raw);
    if (!sender_calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        angle_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    angle_bus.valid        <= 1'b1;
    angle_bus.attack_angle <= raw;
    @(posedge clk_i);
    while (!angle_bus.ready) @(posedge clk_i);
    ledger.note_angle(raw);
  endtask

  function automatic logic [ANGLE_W-1:0] signed_pick(int magnitude);
    int v;
    v = ($urandom_range(1) != 0) ? -magnitude : magnitude;
    return v[ANGLE_W-1:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] random_angle();
    int  r;
    int  k;
    real edge_pos;
    r = $urandom_range(99);
    if (r < 65) begin
      return signed_pick($urandom_range(25735));
    end else if (r < 78) begin
      // around a segment boundary, ten degrees apart
      k = $urandom_range(1, 18);
      edge_pos = k * 1429.7;
      return signed_pick(int'(edge_pos) + $urandom_range(4) - 2);
    end else if (r < 86) begin
      return signed_pick($urandom_range(25730, 25742));
    end else if (r < 94) begin
      return signed_pick($urandom_range(25736, 32767));
    end else begin
      return ANGLE_W'($urandom());
    end
  endfunction

  initial begin
    logic [ANGLE_W-1:0] directed[$];
    int                 n;
    directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd2, 16'sd1429, 16'sd1430, -16'sd1430,
                 16'sd8192, -16'sd8192, 16'sd12868, -16'sd12868, 16'sd25735,
                 -16'sd25735, 16'sd25736, -16'sd25736, 16'sd25737, 16'sd32767,
                 -16'sd32767, 16'h8000, 16'h5555, 16'hAAAA, 16'h7FFE};
    sender_calm             = 1'b0;
    angle_bus.valid        <= 1'b0;
    angle_bus.attack_angle <= '0;
    rst_ni                 <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    n = 0;
    foreach (directed[i]) begin
      send_angle(directed[i]);
      n++;
    end
    while (n < ITEM_COUNT) begin
      sender_calm = (n >= CALM_FIRST) && (n < CALM_LAST);
      send_angle(random_angle());
      n++;
    end
    angle_bus.valid <= 1'b0;
    while (ledger.pending_coeffs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.pending_coeffs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (ledger.pending_coeffs.size() != 0)
        $display("%0d results never arrived", ledger.pending_coeffs.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back up the pipeline, one calm stretch
  initial begin
    int cyc;
    coeff_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    cyc = 0;
    forever begin
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
        coeff_bus.ready <= 1'b0;
      else if (cyc >= READY_CALM_A && cyc < READY_CALM_B)
        coeff_bus.ready <= 1'b1;
      else
        coeff_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      @(posedge clk_i);
      cyc++;
    end
  end

  always @(posedge clk_i) begin
    coeff_set_t got_c;
    if (rst_ni && coeff_bus.valid && coeff_bus.ready) begin
      got_c.axial   = coeff_bus.axial_coeff;
      got_c.normal  = coeff_bus.normal_coeff;
      got_c.clamped = coeff_bus.angle_clamped;
      ledger.check_coeffs(got_c);
    end
  end

  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fci_pkg.sv
rtl/fci_angle_if.sv
rtl/fci_coeff_if.sv
rtl/fci_segment.sv
rtl/fci_lerp.sv
rtl/force_coefficient_interpolator_unit.sv
test/force_coefficient_interpolator_unit_test.sv
